// File: rtl/abd_pkg.sv
// Package for the audio boxcar decimator: payload structs, configuration
// type and the constants shared by all modules. No dependencies.
`default_nettype none

package abd_pkg;

    localparam int RING_DEPTH  = 8;
    localparam int STEP_FRAMES = 4;
    localparam int FILL_W      = $clog2(RING_DEPTH + 1);
    localparam int SMP_W       = 16;
    localparam int SUM_W       = 19;
    localparam int OUT_W       = 8;

    typedef enum logic {
        CFG_LITTLE_ENDIAN = 1'b0,
        CFG_STEREO_MIX    = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic little_endian;
        logic stereo_mix;
    } t_cfg;

    typedef logic signed [SMP_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [OUT_W-1:0] t_out_smp;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic       buffer_end;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] early_sample;
        logic signed [OUT_W-1:0] late_sample;
        logic signed [OUT_W-1:0] running_max;
        logic signed [OUT_W-1:0] running_min;
    } t_out;

endpackage

`default_nettype wire

// File: rtl/abd_front.sv
// Frame decode, channel mix, eight-tap frame history and fill counter.
// Depends on abd_pkg.
`default_nettype none

module abd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire abd_pkg::t_in      i_in,
    input  wire abd_pkg::t_cfg     i_cfg,
    output logic                   o_emit,
    output abd_pkg::t_sample       o_ring [abd_pkg::RING_DEPTH]
);

    abd_pkg::t_sample                 r_ring [abd_pkg::RING_DEPTH];
    logic [abd_pkg::FILL_W-1:0]       r_fill;
    logic [abd_pkg::FILL_W-1:0]       n_fill;
    abd_pkg::t_sample                 first_smp;
    abd_pkg::t_sample                 second_smp;
    logic signed [abd_pkg::SMP_W:0]   mix_sum;
    logic signed [abd_pkg::SMP_W:0]   mix_adj;
    abd_pkg::t_sample                 frame_val;

    always_comb begin
        if (i_cfg.little_endian) begin
            first_smp  = {i_in.byte1, i_in.byte0};
            second_smp = {i_in.byte3, i_in.byte2};
        end else begin
            first_smp  = {i_in.byte0, i_in.byte1};
            second_smp = {i_in.byte2, i_in.byte3};
        end
        mix_sum = (abd_pkg::SMP_W+1)'(first_smp) + (abd_pkg::SMP_W+1)'(second_smp);
        // Adding the sign bit before the shift makes the halving truncate toward zero.
        mix_adj = mix_sum + (abd_pkg::SMP_W+1)'({1'b0, mix_sum[abd_pkg::SMP_W]});
        if (i_cfg.stereo_mix) begin
            frame_val = mix_adj[abd_pkg::SMP_W:1];
        end else begin
            frame_val = first_smp;
        end
    end

    assign n_fill = r_fill + abd_pkg::FILL_W'(1);
    assign o_emit = i_accept && (n_fill == abd_pkg::FILL_W'(abd_pkg::RING_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_accept) begin
            if (o_emit) begin
                r_fill <= abd_pkg::FILL_W'(abd_pkg::RING_DEPTH - abd_pkg::STEP_FRAMES);
            end else begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_ring[0] <= frame_val;
            for (int k = 1; k < abd_pkg::RING_DEPTH; k++) begin
                r_ring[k] <= r_ring[k-1];
            end
        end
    end

    assign o_ring = r_ring;

endmodule

`default_nettype wire

// File: rtl/abd_sum.sv
// Registered six-term window sums over the frame history; tap zero is newest.
// Depends on abd_pkg.
`default_nettype none

module abd_sum (
    input  wire logic              i_clk,
    input  wire logic              i_load,
    input  wire abd_pkg::t_sample  i_ring [abd_pkg::RING_DEPTH],
    output abd_pkg::t_sum          o_early,
    output abd_pkg::t_sum          o_late
);

    abd_pkg::t_sum r_early;
    abd_pkg::t_sum r_late;
    abd_pkg::t_sum mid;

    assign mid = abd_pkg::t_sum'(i_ring[2]) + abd_pkg::t_sum'(i_ring[3])
               + abd_pkg::t_sum'(i_ring[4]) + abd_pkg::t_sum'(i_ring[5]);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_early <= mid + abd_pkg::t_sum'(i_ring[6]) + abd_pkg::t_sum'(i_ring[7]);
            r_late  <= mid + abd_pkg::t_sum'(i_ring[0]) + abd_pkg::t_sum'(i_ring[1]);
        end
    end

    assign o_early = r_early;
    assign o_late  = r_late;

endmodule

`default_nettype wire

// File: rtl/abd_div.sv
// Registered division of one window sum by 1536, truncating toward zero,
// as a shift by 9 and a reciprocal multiply by one third. Depends on abd_pkg.
`default_nettype none

module abd_div (
    input  wire logic              i_clk,
    input  wire logic              i_load,
    input  wire abd_pkg::t_sum     i_sum,
    output abd_pkg::t_out_smp      o_quot
);

    localparam int ABS_W = abd_pkg::SUM_W - 1;
    localparam int T_W   = ABS_W - 9;
    localparam int RCP_W = 11;
    localparam int P_W   = T_W + RCP_W;

    abd_pkg::t_out_smp    r_quot;
    logic                 neg;
    logic [ABS_W-1:0]     mag;
    logic [T_W-1:0]       mag_hi;
    logic [P_W-1:0]       prod;
    logic [T_W-1:0]       q_mag;
    logic [T_W-1:0]       q_signed;

    always_comb begin
        neg = i_sum[abd_pkg::SUM_W-1];
        if (neg) begin
            mag = ABS_W'(-i_sum);
        end else begin
            mag = ABS_W'(i_sum);
        end
        mag_hi = mag[ABS_W-1:9];
        prod   = P_W'(mag_hi) * P_W'(RCP_W'(683));
        q_mag  = prod[P_W-1:RCP_W];
        if (neg) begin
            q_signed = -q_mag;
        end else begin
            q_signed = q_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quot <= q_signed[abd_pkg::OUT_W-1:0];
        end
    end

    assign o_quot = r_quot;

endmodule

`default_nettype wire

// File: rtl/audio_boxcar_decimator.sv
// Top level of the audio boxcar decimator: configuration registers, stage
// handshake, result register and running extremes.
// Depends on abd_pkg, abd_front, abd_sum and abd_div.
//
//   Channel   Direction  Handshake                   Payload
//   input     in         i_in_valid / o_in_ready     i_in  (abd_pkg::t_in)
//   output    out        o_out_valid / i_out_ready   o_out (abd_pkg::t_out)
//   config    in         i_cfg_we                    i_cfg_index, i_cfg_wdata
//
// One frame transaction is taken per cycle while o_in_ready is high. A
// transaction that completes a window passes its result through the frame
// history, sum, divide and result registers. Reset is synchronous and active
// low and clears the fill count, the stage valids and the running extremes. A
// stall on the output fills the stages one by one; input stops only once the
// stage that holds a finished window cannot pass it on.
`default_nettype none

module audio_boxcar_decimator (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire abd_pkg::t_in    i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output abd_pkg::t_out        o_out,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_index,
    input  wire logic            i_cfg_wdata
);

    abd_pkg::t_cfg       r_cfg;
    logic                r_s1_valid;
    logic                r_s2_valid;
    logic                r_s3_valid;
    logic                r_out_valid;
    abd_pkg::t_out       r_out;
    abd_pkg::t_out_smp   r_max;
    abd_pkg::t_out_smp   r_min;
    abd_pkg::t_out_smp   n_max;
    abd_pkg::t_out_smp   n_min;
    abd_pkg::t_out_smp   pair_max;
    abd_pkg::t_out_smp   pair_min;

    logic                in_accept;
    logic                emit;
    logic                adv_s2;
    logic                adv_s3;
    logic                adv_out;
    abd_pkg::t_sample    ring [abd_pkg::RING_DEPTH];
    abd_pkg::t_sum       sum_early;
    abd_pkg::t_sum       sum_late;
    abd_pkg::t_out_smp   q_early;
    abd_pkg::t_out_smp   q_late;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.little_endian <= 1'b1;
            r_cfg.stereo_mix    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (abd_pkg::t_cfg_index'(i_cfg_index))
                abd_pkg::CFG_LITTLE_ENDIAN: r_cfg.little_endian <= i_cfg_wdata;
                abd_pkg::CFG_STEREO_MIX:    r_cfg.stereo_mix    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign adv_out    = r_s3_valid && (!r_out_valid || i_out_ready);
    assign adv_s3     = r_s2_valid && (!r_s3_valid || adv_out);
    assign adv_s2     = r_s1_valid && (!r_s2_valid || adv_s3);
    assign o_in_ready = !r_s1_valid || adv_s2;
    assign in_accept  = i_in_valid && o_in_ready;

    abd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .o_emit   (emit),
        .o_ring   (ring)
    );

    abd_sum u_sum (
        .i_clk   (i_clk),
        .i_load  (adv_s2),
        .i_ring  (ring),
        .o_early (sum_early),
        .o_late  (sum_late)
    );

    abd_div u_div_early (
        .i_clk  (i_clk),
        .i_load (adv_s3),
        .i_sum  (sum_early),
        .o_quot (q_early)
    );

    abd_div u_div_late (
        .i_clk  (i_clk),
        .i_load (adv_s3),
        .i_sum  (sum_late),
        .o_quot (q_late)
    );

    always_comb begin
        pair_max = (q_early > q_late) ? q_early : q_late;
        pair_min = (q_early < q_late) ? q_early : q_late;
        n_max    = (pair_max > r_max) ? pair_max : r_max;
        n_min    = (pair_min < r_min) ? pair_min : r_min;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max       <= {1'b1, {(abd_pkg::OUT_W-1){1'b0}}};
            r_min       <= {1'b0, {(abd_pkg::OUT_W-1){1'b1}}};
        end else begin
            if (emit) begin
                r_s1_valid <= 1'b1;
            end else if (adv_s2) begin
                r_s1_valid <= 1'b0;
            end
            if (adv_s2) begin
                r_s2_valid <= 1'b1;
            end else if (adv_s3) begin
                r_s2_valid <= 1'b0;
            end
            if (adv_s3) begin
                r_s3_valid <= 1'b1;
            end else if (adv_out) begin
                r_s3_valid <= 1'b0;
            end
            if (adv_out) begin
                r_out_valid <= 1'b1;
                r_max       <= n_max;
                r_min       <= n_min;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out) begin
            r_out.early_sample <= q_early;
            r_out.late_sample  <= q_late;
            r_out.running_max  <= n_max;
            r_out.running_min  <= n_min;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_extremes_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.running_max >= r_out.early_sample)
                     && (r_out.running_max >= r_out.late_sample)
                     && (r_out.running_min <= r_out.early_sample)
                     && (r_out.running_min <= r_out.late_sample))
        else $error("running extremes do not bound the delivered pair");

    a_max_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_max >= $past(r_max)))
        else $error("running maximum decreased");

    a_min_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_min <= $past(r_min)))
        else $error("running minimum increased");

endmodule

`default_nettype wire
